### design/ifr_pkg.sv
// ----------------------------------------------------------------------------
// ifr_pkg
// shared types and constants for the info frame receiver with destuffing
// ----------------------------------------------------------------------------
`default_nettype none

package ifr_pkg;

  // payload length counter width
  localparam int LEN_WIDTH = 16;
  // width of the reported length field
  localparam int LEN_OUT_W = 16;

  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_FLAG  = 8'h5E;
  localparam logic [7:0] ESC_ESC   = 8'h5D;

  // op queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ADDRESS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL0    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL1    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RR0      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RR1      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REJ0     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_REJ1     = 3'd6;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_FLAG,
    PH_ADDR,
    PH_CTRL,
    PH_DATA,
    PH_ESC
  } phase_t;

  typedef enum logic [1:0] {
    OP_DATA,
    OP_CLOSE,
    OP_ABORT
  } op_kind_t;

  typedef enum logic [1:0] {
    EV_PAYLOAD = 2'd0,
    EV_ACCEPT  = 2'd1,
    EV_REJECT  = 2'd2,
    EV_ABORT   = 2'd3
  } ev_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] data;
    logic       seq;
  } op_t;

  typedef struct packed {
    logic [7:0] address_byte;
    logic [7:0] ctrl_seq0;
    logic [7:0] ctrl_seq1;
    logic [7:0] ready_code0;
    logic [7:0] ready_code1;
    logic [7:0] reject_code0;
    logic [7:0] reject_code1;
  } cfg_t;

endpackage

`default_nettype wire

### design/ifr_front.sv
// ----------------------------------------------------------------------------
// ifr_front
// flag hunt, header check and byte destuffing; emits ops to the back end
// ----------------------------------------------------------------------------
`default_nettype none

module ifr_front import ifr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_t       cfg,
  input  wire logic       accept,
  input  wire logic [7:0] rx_byte,
  output      logic       op_push,
  output      op_t        op
);

  phase_t     phase;
  phase_t     phase_next;
  logic [7:0] frame_ctrl;
  logic       seq_bit;

  // next state
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_HUNT: begin
        if (rx_byte == FLAG_BYTE) phase_next = PH_FLAG;
      end
      PH_FLAG: begin
        if (rx_byte == cfg.address_byte) phase_next = PH_ADDR;
        else if (rx_byte != FLAG_BYTE) phase_next = PH_HUNT;
      end
      PH_ADDR: begin
        if (rx_byte == cfg.ctrl_seq0 || rx_byte == cfg.ctrl_seq1) phase_next = PH_CTRL;
        else if (rx_byte == FLAG_BYTE) phase_next = PH_FLAG;
        else phase_next = PH_HUNT;
      end
      PH_CTRL: begin
        if (rx_byte == (cfg.address_byte ^ frame_ctrl)) phase_next = PH_DATA;
        else phase_next = PH_HUNT;
      end
      PH_DATA: begin
        if (rx_byte == FLAG_BYTE) phase_next = PH_HUNT;
        else if (rx_byte == ESC_BYTE) phase_next = PH_ESC;
      end
      PH_ESC: begin
        if (rx_byte == ESC_FLAG || rx_byte == ESC_ESC) phase_next = PH_DATA;
        else phase_next = PH_HUNT;
      end
      default: phase_next = PH_HUNT;
    endcase
  end

  // op generation
  always_comb begin
    op_push  = 1'b0;
    op.kind  = OP_DATA;
    op.data  = rx_byte;
    op.seq   = seq_bit;
    case (phase)
      PH_DATA: begin
        if (rx_byte == FLAG_BYTE) begin
          op_push = accept;
          op.kind = OP_CLOSE;
        end else if (rx_byte != ESC_BYTE) begin
          op_push = accept;
        end
      end
      PH_ESC: begin
        op_push = accept;
        if (rx_byte == ESC_FLAG) begin
          op.data = FLAG_BYTE;
        end else if (rx_byte == ESC_ESC) begin
          op.data = ESC_BYTE;
        end else begin
          op.kind = OP_ABORT;
        end
      end
      default: op_push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT;
      frame_ctrl <= 8'd0;
      seq_bit    <= 1'b0;
    end else if (accept) begin
      phase <= phase_next;
      if (phase == PH_ADDR) begin
        if (rx_byte == cfg.ctrl_seq0) begin
          seq_bit    <= 1'b1;
          frame_ctrl <= rx_byte;
        end else if (rx_byte == cfg.ctrl_seq1) begin
          seq_bit    <= 1'b0;
          frame_ctrl <= rx_byte;
        end
      end
    end
  end

endmodule

`default_nettype wire

### design/ifr_queue.sv
// ----------------------------------------------------------------------------
// ifr_queue
// small first-in first-out queue of ops between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module ifr_queue import ifr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire op_t  push_op,
  output      logic full,
  input  wire logic pop,
  output      logic pop_valid,
  output      op_t  pop_op
);

  op_t               entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;
  logic              do_push;
  logic              do_pop;

  assign full      = (fill == (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid = (fill != '0);
  assign pop_op    = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) fill <= fill + 1'b1;
      else if (!do_push && do_pop) fill <= fill - 1'b1;
    end
  end

endmodule

`default_nettype wire

### design/ifr_back.sv
// ----------------------------------------------------------------------------
// ifr_back
// one-byte holdback, block check, length count and result register
// ----------------------------------------------------------------------------
`default_nettype none

module ifr_back import ifr_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire cfg_t                 cfg,
  input  wire logic                 op_valid,
  input  wire op_t                  op,
  output      logic                 op_pop,
  output      logic                 out_valid,
  input  wire logic                 out_ready,
  output      ev_kind_t             event_kind,
  output      logic [7:0]           payload_byte,
  output      logic [7:0]           reply_code,
  output      logic [LEN_OUT_W-1:0] payload_len,
  output      logic                 next_seq
);

  logic [7:0]           held_byte;
  logic                 held_valid;
  logic [7:0]           xor_acc;
  logic [LEN_WIDTH-1:0] byte_count;

  logic                 take;
  logic                 emit;
  logic                 frame_ok;
  ev_kind_t             ev_next;
  logic [7:0]           code_next;
  logic [7:0]           pbyte_next;
  logic [LEN_OUT_W-1:0] len_next;

  assign take   = op_valid && (!out_valid || out_ready);
  assign op_pop = take;

  assign frame_ok = held_valid && (xor_acc == held_byte);

  always_comb begin
    emit       = 1'b0;
    ev_next    = EV_PAYLOAD;
    pbyte_next = 8'd0;
    code_next  = 8'd0;
    len_next   = '0;
    case (op.kind)
      OP_DATA: begin
        emit       = held_valid;
        pbyte_next = held_byte;
      end
      OP_CLOSE: begin
        emit = 1'b1;
        if (frame_ok) begin
          ev_next   = EV_ACCEPT;
          code_next = op.seq ? cfg.ready_code1 : cfg.ready_code0;
        end else begin
          ev_next   = EV_REJECT;
          code_next = op.seq ? cfg.reject_code1 : cfg.reject_code0;
        end
        if (held_valid) len_next = LEN_OUT_W'(byte_count);
      end
      OP_ABORT: begin
        emit    = 1'b1;
        ev_next = EV_ABORT;
      end
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      held_byte  <= 8'd0;
      xor_acc    <= 8'd0;
      byte_count <= '0;
    end else if (take) begin
      if (op.kind == OP_DATA) begin
        held_byte  <= op.data;
        held_valid <= 1'b1;
        if (held_valid) begin
          xor_acc <= xor_acc ^ held_byte;
          if (byte_count != '1) byte_count <= byte_count + 1'b1;
        end
      end else begin
        held_valid <= 1'b0;
        xor_acc    <= 8'd0;
        byte_count <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      event_kind   <= ev_next;
      payload_byte <= pbyte_next;
      reply_code   <= code_next;
      payload_len  <= len_next;
      next_seq     <= op.seq;
    end
  end

  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    (take && op.kind != OP_DATA) |=> (!held_valid && xor_acc == 8'd0 && byte_count == '0))
    else $error("frame end did not clear holdback state");

  a_data_holds: assert property (@(posedge clk) disable iff (rst)
    (take && op.kind == OP_DATA) |=> held_valid)
    else $error("data op did not fill the holdback byte");

  a_pbyte_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_kind != EV_PAYLOAD) |-> (payload_byte == 8'd0))
    else $error("payload byte not zero on a frame status");

  a_len_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (event_kind == EV_PAYLOAD || event_kind == EV_ABORT))
      |-> (payload_len == '0 && reply_code == 8'd0))
    else $error("length or reply code set on payload or abort");

endmodule

`default_nettype wire

### design/info_frame_receiver_destuff_bcc_unit.sv
// ----------------------------------------------------------------------------
// info_frame_receiver_destuff_bcc_unit
// information frame receiver: flag hunt, header check, destuffing, xor check
// ----------------------------------------------------------------------------
// path: a byte's op enters the op queue at the edge that accepts the byte,
//   and the back end's result register loads from the queue head when the
//   result side is not stalled
// throughput: one received byte per cycle while the op queue is not full, set by the front state machine
//   and the back end each handling one op per clock
// reset: synchronous, clears the frame state and the op queue and loads the
//   default configuration; no clearing pass
`default_nettype none

module info_frame_receiver_destuff_bcc_unit import ifr_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // receive byte stream
  input  wire logic                 s_tvalid,
  output      logic                 s_tready,
  input  wire logic [7:0]           s_tdata,   // [7:0] rx_byte
  // result stream
  output      logic                 m_tvalid,
  input  wire logic                 m_tready,
  output      logic [39:0]          m_tdata,   // [7:0] payload_byte, [15:8] reply_code,
                                               // [31:16] payload_len, [32] next_seq
  output      logic [1:0]           m_tuser,   // [1:0] event_kind
  // configuration writes
  input  wire logic                 cfg_valid,
  output      logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data
);

  cfg_t                 cfg;
  logic                 in_accept;
  logic                 q_full;
  logic                 front_push;
  op_t                  front_op;
  logic                 q_valid;
  op_t                  q_op;
  logic                 q_pop;
  ev_kind_t             ev_kind;
  logic [7:0]           pbyte;
  logic [7:0]           rcode;
  logic [LEN_OUT_W-1:0] plen;
  logic                 nseq;

  // configuration registers, always ready; the user must write them only while idle, the block does not enforce it
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.address_byte <= 8'h03;
      cfg.ctrl_seq0    <= 8'h00;
      cfg.ctrl_seq1    <= 8'h40;
      cfg.ready_code0  <= 8'h05;
      cfg.ready_code1  <= 8'h85;
      cfg.reject_code0 <= 8'h01;
      cfg.reject_code1 <= 8'h81;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ADDRESS: cfg.address_byte <= cfg_data;
        REG_CTRL0:   cfg.ctrl_seq0    <= cfg_data;
        REG_CTRL1:   cfg.ctrl_seq1    <= cfg_data;
        REG_RR0:     cfg.ready_code0  <= cfg_data;
        REG_RR1:     cfg.ready_code1  <= cfg_data;
        REG_REJ0:    cfg.reject_code0 <= cfg_data;
        REG_REJ1:    cfg.reject_code1 <= cfg_data;
        default:     ;  // unmapped index, write dropped
      endcase
    end
  end

  // the front takes a byte whenever the op queue has room; every byte makes
  // at most one op, so a free slot is all it needs
  assign s_tready  = !q_full;
  assign in_accept = s_tvalid && s_tready;

  ifr_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .accept  (in_accept),
    .rx_byte (s_tdata),
    .op_push (front_push),
    .op      (front_op)
  );

  // decouples the byte side from result back-pressure
  ifr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (front_push),
    .push_op   (front_op),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_op    (q_op)
  );

  // holdback byte, bcc2 check, length count and the result register
  ifr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .op_valid     (q_valid),
    .op           (q_op),
    .op_pop       (q_pop),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .event_kind   (ev_kind),
    .payload_byte (pbyte),
    .reply_code   (rcode),
    .payload_len  (plen),
    .next_seq     (nseq)
  );

  // pack result fields, low field first, padded to whole bytes
  assign m_tuser = ev_kind;
  assign m_tdata = {7'd0, nseq, plen, rcode, pbyte};

endmodule

`default_nettype wire

### tb/sv/info_frame_receiver_destuff_bcc_unit_test.sv
// ----------------------------------------------------------------------------
// info_frame_receiver_destuff_bcc_unit_test
// self-checking bench for the destuffing information frame receiver: a short
// directed byte table, then randomized frames under several register settings,
// with each result checked against the directed table or a behavioral frame decoder in the bench
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module info_frame_receiver_destuff_bcc_unit_test import ifr_pkg::*; ();

  localparam int QUIET_LIMIT  = 2000;  // cycles with no transaction at all
  localparam int SETTLE       = 8;     // covers the queue and result register tail of the byte to result path
  localparam int LONG_HOLD    = 64;    // long result-side hold-off
  localparam int PHASE_BYTES  = 456;   // frame bytes per random phase

  // one result as the bench expects it
  typedef struct packed {
    ev_kind_t    kind;
    logic [7:0]  pbyte;
    logic [7:0]  code;
    logic [15:0] len;
    logic        seq;
  } frame_event_t;

  // directed table row; typed rows carry their result, the rest use the decoder
  typedef struct {
    logic [7:0]  rx;
    bit          typed;
    ev_kind_t    kind;
    logic [7:0]  pbyte;
    logic [7:0]  code;
    logic [15:0] len;
    logic        seq;
  } dir_row_t;

  typedef enum {
    FR_GOOD,
    FR_BAD_BCC2,
    FR_EMPTY,
    FR_BAD_ESC,
    FR_BAD_HDR,
    FR_NOISE
  } frame_flavor_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata = 8'h00;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [39:0]          m_tdata;     // [7:0] payload_byte, [15:8] reply_code,
                                     // [31:16] payload_len, [32] next_seq
  logic [1:0]           m_tuser;     // [1:0] event_kind
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = 8'h00;

  // decoder copy of the registers, reset values
  cfg_t model_cfg = '{8'h03, 8'h00, 8'h40, 8'h05, 8'h85, 8'h01, 8'h81};

  // decoder frame state, reset values
  phase_t               rx_phase = PH_HUNT;
  logic [7:0]           rx_ctrl = 8'h00;
  logic                 rx_seq = 1'b0;
  logic [7:0]           held_byte = 8'h00;
  logic                 held_valid = 1'b0;
  logic [7:0]           payload_xor = 8'h00;
  logic [LEN_WIDTH-1:0] payload_cnt = '0;

  frame_event_t due_events[$];   // results still owed by the block
  logic [7:0]   line_bytes[$];   // raw bytes of the frame being sent

  int err_count   = 0;
  int frame_bytes = 0;
  int quiet       = 0;
  int src_pct     = 25;
  int sink_pct    = 25;
  int sink_wait   = 0;
  bit calm        = 1'b0;
  bit hold_request = 1'b0;

  // directed bytes at reset settings
  dir_row_t dir_tab [25] = '{
    '{8'h7E, 0, EV_PAYLOAD, 0, 0, 0, 0},      // opening flag
    '{8'h7E, 0, EV_PAYLOAD, 0, 0, 0, 0},      // flag where address expected
    '{8'h03, 0, EV_PAYLOAD, 0, 0, 0, 0},
    '{8'h7E, 0, EV_PAYLOAD, 0, 0, 0, 0},      // flag where control expected
    '{8'h03, 0, EV_PAYLOAD, 0, 0, 0, 0},
    '{8'h00, 0, EV_PAYLOAD, 0, 0, 0, 0},      // sequence 0 control sets seq bit
    '{8'h03, 0, EV_PAYLOAD, 0, 0, 0, 0},      // bcc1
    '{8'hFF, 0, EV_PAYLOAD, 0, 0, 0, 0},
    '{8'h7D, 0, EV_PAYLOAD, 0, 0, 0, 0},
    '{8'h5E, 1, EV_PAYLOAD, 8'hFF, 0, 0, 1},  // escaped flag releases 0xff
    '{8'h7D, 0, EV_PAYLOAD, 0, 0, 0, 0},
    '{8'h5D, 0, EV_PAYLOAD, 0, 0, 0, 0},      // escaped escape
    '{8'h7D, 0, EV_PAYLOAD, 0, 0, 0, 0},
    '{8'h7E, 1, EV_ABORT, 0, 0, 0, 1},        // flag after escape aborts
    '{8'h7E, 0, EV_PAYLOAD, 0, 0, 0, 0},
    '{8'h03, 0, EV_PAYLOAD, 0, 0, 0, 0},
    '{8'h40, 0, EV_PAYLOAD, 0, 0, 0, 0},      // sequence 1 control clears seq bit
    '{8'h43, 0, EV_PAYLOAD, 0, 0, 0, 0},
    '{8'h7E, 1, EV_REJECT, 0, 8'h01, 0, 0},   // empty frame, no bcc2
    '{8'h7E, 0, EV_PAYLOAD, 0, 0, 0, 0},
    '{8'h03, 0, EV_PAYLOAD, 0, 0, 0, 0},
    '{8'h40, 0, EV_PAYLOAD, 0, 0, 0, 0},
    '{8'h43, 0, EV_PAYLOAD, 0, 0, 0, 0},
    '{8'h00, 0, EV_PAYLOAD, 0, 0, 0, 0},      // bcc2 only, xor of nothing is zero
    '{8'h7E, 1, EV_ACCEPT, 0, 8'h05, 0, 0}
  };

  info_frame_receiver_destuff_bcc_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ------------------------------------------------------------------------
  // frame decoder
  // ------------------------------------------------------------------------

  // holds d back and releases the byte held before it
  function automatic bit shift_payload(input logic [7:0] d, output frame_event_t ev);
    ev = '{EV_PAYLOAD, held_byte, 8'h00, 16'h0000, rx_seq};
    shift_payload = held_valid;
    if (held_valid) begin
      payload_xor = payload_xor ^ held_byte;
      if (payload_cnt != '1) payload_cnt = payload_cnt + 1'b1;
    end
    held_byte  = d;
    held_valid = 1'b1;
  endfunction

  // advances the decoder by one received byte
  function automatic void frame_step(input logic [7:0] b, output bit has,
                                     output frame_event_t ev);
    bit ok;
    has = 1'b0;
    ev  = '0;
    case (rx_phase)
      PH_HUNT: begin
        if (b == FLAG_BYTE) rx_phase = PH_FLAG;
      end
      PH_FLAG: begin
        if (b == model_cfg.address_byte) rx_phase = PH_ADDR;
        else if (b != FLAG_BYTE) rx_phase = PH_HUNT;
      end
      PH_ADDR: begin
        // seq bit flips to the sequence asked for next, kept even if bcc1 fails
        if (b == model_cfg.ctrl_seq0) begin
          rx_seq   = 1'b1;
          rx_ctrl  = b;
          rx_phase = PH_CTRL;
        end else if (b == model_cfg.ctrl_seq1) begin
          rx_seq   = 1'b0;
          rx_ctrl  = b;
          rx_phase = PH_CTRL;
        end else if (b == FLAG_BYTE) begin
          rx_phase = PH_FLAG;
        end else begin
          rx_phase = PH_HUNT;
        end
      end
      PH_CTRL: begin
        if (b == (model_cfg.address_byte ^ rx_ctrl)) begin
          rx_phase    = PH_DATA;
          held_byte   = 8'h00;
          held_valid  = 1'b0;
          payload_xor = 8'h00;
          payload_cnt = '0;
        end else begin
          rx_phase = PH_HUNT;
        end
      end
      PH_DATA: begin
        if (b == FLAG_BYTE) begin
          // held byte is bcc2, compared with the xor of everything released
          ok = held_valid && (payload_xor == held_byte);
          ev.kind = ok ? EV_ACCEPT : EV_REJECT;
          if (ok) ev.code = rx_seq ? model_cfg.ready_code1 : model_cfg.ready_code0;
          else    ev.code = rx_seq ? model_cfg.reject_code1 : model_cfg.reject_code0;
          ev.len  = held_valid ? LEN_OUT_W'(payload_cnt) : '0;
          ev.seq  = rx_seq;
          has        = 1'b1;
          rx_phase   = PH_HUNT;
          held_valid = 1'b0;
        end else if (b == ESC_BYTE) begin
          rx_phase = PH_ESC;
        end else begin
          has = shift_payload(b, ev);
        end
      end
      PH_ESC: begin
        if (b == ESC_FLAG) begin
          rx_phase = PH_DATA;
          has = shift_payload(FLAG_BYTE, ev);
        end else if (b == ESC_ESC) begin
          rx_phase = PH_DATA;
          has = shift_payload(ESC_BYTE, ev);
        end else begin
          // bad escape drops the held byte
          ev         = '{EV_ABORT, 8'h00, 8'h00, 16'h0000, rx_seq};
          has        = 1'b1;
          rx_phase   = PH_HUNT;
          held_valid = 1'b0;
        end
      end
      default: rx_phase = PH_HUNT;
    endcase
  endfunction

  // ------------------------------------------------------------------------
  // receive byte side
  // ------------------------------------------------------------------------

  // offers one byte and returns at the edge that takes it
  task automatic drive_byte(input logic [7:0] b);
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // random sender idle gap, skipped while calm
  task automatic src_gap();
    if (!calm && src_pct != 0 && $urandom_range(0, 99) < src_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    bit           has;
    frame_event_t ev;
    drive_byte(b);
    frame_step(b, has, ev);
    if (has) due_events.push_back(ev);
    src_gap();
  endtask

  function automatic void push_stuffed(input logic [7:0] d);
    if (d == FLAG_BYTE) begin
      line_bytes.push_back(ESC_BYTE);
      line_bytes.push_back(ESC_FLAG);
    end else if (d == ESC_BYTE) begin
      line_bytes.push_back(ESC_BYTE);
      line_bytes.push_back(ESC_ESC);
    end else begin
      line_bytes.push_back(d);
    end
  endfunction

  // builds one frame of the given flavor under the current settings and sends it
  task automatic send_frame(input frame_flavor_t fl, input int plen);
    logic [7:0] ctl;
    logic [7:0] d;
    logic [7:0] chk;
    int         i;
    line_bytes.delete();
    ctl = $urandom_range(0, 1) ? model_cfg.ctrl_seq0 : model_cfg.ctrl_seq1;
    if (fl == FR_NOISE) begin
      repeat ($urandom_range(1, 4)) line_bytes.push_back(8'($urandom));
    end else begin
      line_bytes.push_back(FLAG_BYTE);
      line_bytes.push_back(model_cfg.address_byte);
      line_bytes.push_back(ctl);
      line_bytes.push_back(model_cfg.address_byte ^ ctl);
      // damage address, control or bcc1
      if (fl == FR_BAD_HDR) begin
        i = $urandom_range(1, 3);
        line_bytes[i] = line_bytes[i] ^ 8'($urandom_range(1, 255));
      end
      if (fl != FR_EMPTY) begin
        chk = 8'h00;
        for (i = 0; i < plen; i++) begin
          // lean on the bytes that need stuffing
          if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 3))
              0:       d = FLAG_BYTE;
              1:       d = ESC_BYTE;
              2:       d = ESC_FLAG;
              default: d = ESC_ESC;
            endcase
          end else begin
            d = 8'($urandom);
          end
          chk = chk ^ d;
          push_stuffed(d);
        end
        if (fl == FR_BAD_ESC) begin
          do d = 8'($urandom); while (d == ESC_FLAG || d == ESC_ESC);
          line_bytes.push_back(ESC_BYTE);
          line_bytes.push_back(d);
        end else begin
          if (fl == FR_BAD_BCC2) chk = chk ^ 8'($urandom_range(1, 255));
          push_stuffed(chk);
        end
      end
      if (fl != FR_BAD_ESC) line_bytes.push_back(FLAG_BYTE);
      frame_bytes += line_bytes.size();
    end
    foreach (line_bytes[k]) send_byte(line_bytes[k]);
  endtask

  // stops sending and waits for every owed result plus the pipeline tail
  task automatic drain();
    s_tvalid <= 1'b0;
    while (due_events.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // ------------------------------------------------------------------------
  // configuration side
  // ------------------------------------------------------------------------

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ADDRESS: model_cfg.address_byte = val;
      REG_CTRL0:   model_cfg.ctrl_seq0    = val;
      REG_CTRL1:   model_cfg.ctrl_seq1    = val;
      REG_RR0:     model_cfg.ready_code0  = val;
      REG_RR1:     model_cfg.ready_code1  = val;
      REG_REJ0:    model_cfg.reject_code0 = val;
      REG_REJ1:    model_cfg.reject_code1 = val;
      default: ;
    endcase
    // keeps back-to-back writes apart so cfg_valid never toggles in one step
    @(posedge clk);
  endtask

  task automatic load_config(input cfg_t c);
    write_reg(REG_ADDRESS, c.address_byte);
    write_reg(REG_CTRL0,   c.ctrl_seq0);
    write_reg(REG_CTRL1,   c.ctrl_seq1);
    write_reg(REG_RR0,     c.ready_code0);
    write_reg(REG_RR1,     c.ready_code1);
    write_reg(REG_REJ0,    c.reject_code0);
    write_reg(REG_REJ1,    c.reject_code1);
  endtask

  // ------------------------------------------------------------------------
  // result side: checker and ready pattern
  // ------------------------------------------------------------------------

  always @(posedge clk) begin
    frame_event_t want;
    frame_event_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = '{ev_kind_t'(m_tuser), m_tdata[7:0], m_tdata[15:8], m_tdata[31:16],
              m_tdata[32]};
      if (due_events.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result, got kind %0d byte %h code %h len %0d seq %0d",
                 $time, got.kind, got.pbyte, got.code, got.len, got.seq);
      end else begin
        want = due_events.pop_front();
        if (got != want) begin
          err_count++;
          $display({"%0t: mismatch, expected kind %0d byte %h code %h len %0d seq %0d,",
                    " got kind %0d byte %h code %h len %0d seq %0d"},
                   $time, want.kind, want.pbyte, want.code, want.len, want.seq,
                   got.kind, got.pbyte, got.code, got.len, got.seq);
        end
      end
    end
    // ready pattern: long hold on request, else short random bursts
    if (sink_wait > 0) begin
      sink_wait--;
      m_tready <= 1'b0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      sink_wait = LONG_HOLD - 1;
      m_tready <= 1'b0;
    end else if (!calm && sink_pct != 0 && $urandom_range(0, 99) < sink_pct) begin
      sink_wait = $urandom_range(0, 2);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // watchdog on cycles with no transaction anywhere
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("%0t: watchdog, no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // ------------------------------------------------------------------------
  // main sequence
  // ------------------------------------------------------------------------

  initial begin
    bit            has;
    frame_event_t  ev;
    cfg_t          nc;
    frame_flavor_t fl;
    int            ph;
    int            r;
    int            plen;
    int            src_base;
    int            sink_base;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed bytes, typed rows carry their own result
    foreach (dir_tab[i]) begin
      drive_byte(dir_tab[i].rx);
      frame_step(dir_tab[i].rx, has, ev);
      if (dir_tab[i].typed)
        due_events.push_back('{dir_tab[i].kind, dir_tab[i].pbyte, dir_tab[i].code,
                               dir_tab[i].len, dir_tab[i].seq});
      else if (has)
        due_events.push_back(ev);
      src_gap();
    end

    // random phases; phase 0 at reset settings, then two fixed mixes of 0xff and
    // 0x00 registers, and a random setting run without idling
    for (ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        1: nc = '{8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00};
        2: nc = '{8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF};
        3: nc = '{8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom), 8'($urandom), 8'($urandom)};
        default: nc = model_cfg;
      endcase
      if (ph != 0) load_config(nc);
      src_base  = (ph == 1) ? 10 : 35;
      sink_base = (ph == 1) ? 45 : 20;
      calm      = (ph == 3);

      // long result-side hold while the sender keeps offering a long frame
      if (ph == 1) begin
        src_pct  = 0;
        hold_request = 1'b1;
        send_frame(FR_GOOD, 40);
      end

      while (frame_bytes < (ph + 1) * PHASE_BYTES) begin
        // some frames run with no idling at all
        src_pct  = ($urandom_range(0, 3) == 0) ? 0 : src_base;
        sink_pct = ($urandom_range(0, 3) == 0) ? 0 : sink_base;
        r    = $urandom_range(0, 99);
        plen = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
        if (r < 6)       fl = FR_NOISE;
        else if (r < 13) fl = FR_BAD_HDR;
        else if (r < 20) fl = FR_BAD_ESC;
        else if (r < 26) fl = FR_EMPTY;
        else if (r < 38) fl = FR_BAD_BCC2;
        else             fl = FR_GOOD;
        send_frame(fl, plen);
        // now and then the sender waits for every owed result
        if ($urandom_range(0, 39) == 0) drain();
      end
    end

    drain();
    if (err_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
